@@ sv/gmdc_pkg.sv @@
// Shared types and constants of the grid maze carver.
package gmdc_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CELL_W = ROW_W + COL_W;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int VIS_DEPTH = 2 ** CELL_W;
  localparam int STK_IDX_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);

  localparam int DIM_W = 5;
  localparam int COORD_W = 4;
  localparam int EPOCH_W = 8;
  localparam int RND_W = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd3;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef enum logic [1:0] {
    DIR_EAST  = 2'd0,
    DIR_WEST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_NORTH = 2'd3
  } dir_e;

  typedef struct packed {
    logic             req_type;
    logic [RND_W-1:0] random_word;
  } in_item_t;

  typedef struct packed {
    logic               carved;
    logic [COORD_W-1:0] from_row;
    logic [COORD_W-1:0] from_col;
    logic [COORD_W-1:0] to_row;
    logic [COORD_W-1:0] to_col;
    logic               finished;
  } out_item_t;

  typedef struct packed {
    logic [1:0] idx;
    dir_e       dir;
  } pick_t;

endpackage

@@ sv/gmdc_picker.sv @@
// Direction picker: random word modulo the remaining count, then list lookup.
module gmdc_picker (
  input  logic [gmdc_pkg::RND_W-1:0] random_word,
  input  logic [2:0]                 rem_count,
  input  gmdc_pkg::dir_e [3:0]       rem_dirs,
  output gmdc_pkg::pick_t            pick
);
  import gmdc_pkg::*;

  function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < RND_W / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  logic [1:0] idx;

  always_comb begin
    case (rem_count)
      3'd2: idx = {1'b0, random_word[0]};
      3'd3: idx = mod3(random_word);
      3'd4: idx = random_word[1:0];
      default: idx = 2'd0;
    endcase
    pick.idx = idx;
    pick.dir = rem_dirs[idx];
  end

endmodule

@@ sv/grid_maze_dfs_carver_unit.sv @@
// Top level of the grid maze carver: randomized depth-first walk over a memory-held grid.
// Every request, start or step, is accepted in ST_IDLE, which issues the reads of the visited
// memory and the path stack memory; ST_EXEC then uses the registered read data, writes the
// memories a start or a carve needs and loads the result register, waiting there only while
// an earlier result has not been taken. Visited marks are stored as 8-bit walk tags, so a
// start clears nothing in the common case. After reset, and again on the start that follows every
// 255 starts, the visited memory is swept once over all 256 entries, one entry per cycle; no
// transaction is accepted on the input during the sweep, while configuration writes are.
module grid_maze_dfs_carver_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gmdc_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gmdc_pkg::out_item_t                 out_item,
  input  logic                                cfg_write,
  input  logic [gmdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmdc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gmdc_pkg::*;

  localparam int EXT_W = 8;
  localparam dir_e [3:0] DIRS_FULL = {DIR_NORTH, DIR_SOUTH, DIR_WEST, DIR_EAST};

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [DIM_W-1:0] row_count, col_count;
  logic [COORD_W-1:0] start_row, start_col;

  logic [CELL_W-1:0] clear_addr;
  logic clear_for_start;
  logic [EPOCH_W-1:0] epoch, epoch_next;
  logic [ROW_W-1:0] cur_row, cur_row_next;
  logic [COL_W-1:0] cur_col, cur_col_next;
  logic [CNT_W-1:0] stack_count, stack_count_next;
  dir_e [3:0] rem_dirs, rem_dirs_next;
  logic [2:0] rem_count, rem_count_next;

  logic req_r, off_r, pop_r, active_r;
  logic [1:0] rem_idx_r;
  logic [ROW_W-1:0] nb_row, nb_row_c;
  logic [COL_W-1:0] nb_col, nb_col_c;

  logic [EPOCH_W-1:0] visited_mem [VIS_DEPTH];
  logic [EPOCH_W-1:0] vis_rdata;
  logic [CELL_W-1:0] stack_mem [CELLS];
  logic [CELL_W-1:0] stack_rdata;

  logic vis_we, stk_we;
  logic [CELL_W-1:0] vis_waddr, stk_wdata;
  logic [EPOCH_W-1:0] vis_wdata;
  logic [STK_IDX_W-1:0] stk_waddr, stk_raddr;
  logic [CNT_W-1:0] stack_dec;

  logic in_fire, commit, off_c;
  logic [EXT_W-1:0] rows_x, cols_x, cr_x, cc_x, nr_x, nc_x, sr_x, sc_x;
  logic [ROW_W-1:0] sr;
  logic [COL_W-1:0] sc;
  pick_t pick;
  out_item_t res;

  gmdc_picker u_picker (
    .random_word (in_item.random_word),
    .rem_count   (rem_count),
    .rem_dirs    (rem_dirs),
    .pick        (pick)
  );

  assign in_ready = (state == ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign commit = (state == ST_EXEC) && (!out_valid || out_ready);
  assign stack_dec = stack_count - CNT_W'(1);
  assign stk_raddr = stack_dec[STK_IDX_W-1:0];

  always_comb begin
    rows_x = (row_count == '0) ? EXT_W'(1) :
             (EXT_W'(row_count) > EXT_W'(MAX_ROWS)) ? EXT_W'(MAX_ROWS) : EXT_W'(row_count);
    cols_x = (col_count == '0) ? EXT_W'(1) :
             (EXT_W'(col_count) > EXT_W'(MAX_COLS)) ? EXT_W'(MAX_COLS) : EXT_W'(col_count);
    sr_x = (EXT_W'(start_row) < rows_x) ? EXT_W'(start_row) : rows_x - EXT_W'(1);
    sc_x = (EXT_W'(start_col) < cols_x) ? EXT_W'(start_col) : cols_x - EXT_W'(1);
    sr = sr_x[ROW_W-1:0];
    sc = sc_x[COL_W-1:0];
    cr_x = EXT_W'(cur_row);
    cc_x = EXT_W'(cur_col);
    nr_x = cr_x;
    nc_x = cc_x;
    off_c = 1'b0;
    unique case (pick.dir)
      DIR_EAST: begin
        nc_x = cc_x + EXT_W'(1);
        off_c = (nc_x >= cols_x) || (cr_x >= rows_x);
      end
      DIR_WEST: begin
        nc_x = cc_x - EXT_W'(1);
        off_c = (cc_x == '0) || (cr_x >= rows_x) || (nc_x >= cols_x);
      end
      DIR_SOUTH: begin
        nr_x = cr_x + EXT_W'(1);
        off_c = (nr_x >= rows_x) || (cc_x >= cols_x);
      end
      DIR_NORTH: begin
        nr_x = cr_x - EXT_W'(1);
        off_c = (cr_x == '0) || (cc_x >= cols_x) || (nr_x >= rows_x);
      end
    endcase
    nb_row_c = nr_x[ROW_W-1:0];
    nb_col_c = nc_x[COL_W-1:0];
  end

  always_comb begin
    state_next = state;
    epoch_next = epoch;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    stack_count_next = stack_count;
    rem_dirs_next = rem_dirs;
    rem_count_next = rem_count;
    vis_we = 1'b0;
    vis_waddr = clear_addr;
    vis_wdata = '0;
    stk_we = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    res = '0;
    unique case (state)
      ST_CLEAR: begin
        vis_we = 1'b1;
        if (&clear_addr) begin
          state_next = clear_for_start ? ST_EXEC : ST_IDLE;
          epoch_next = '0;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_item.req_type == REQ_START && (&epoch)) begin
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_next = ST_IDLE;
          if (req_r == REQ_START) begin
            epoch_next = epoch + EPOCH_W'(1);
            vis_we = 1'b1;
            vis_waddr = {sr, sc};
            vis_wdata = epoch_next;
            stk_we = 1'b1;
            stk_waddr = '0;
            stk_wdata = {sr, sc};
            stack_count_next = CNT_W'(1);
            cur_row_next = sr;
            cur_col_next = sc;
            rem_dirs_next = DIRS_FULL;
            rem_count_next = 3'd4;
          end else if (active_r) begin
            if (pop_r) begin
              stack_count_next = stack_dec;
              cur_row_next = stack_rdata[CELL_W-1:COL_W];
              cur_col_next = stack_rdata[COL_W-1:0];
              rem_dirs_next = DIRS_FULL;
              rem_count_next = 3'd4;
            end else if (off_r || vis_rdata == epoch) begin
              for (int k = 0; k < 3; k++) begin
                if (2'(k) >= rem_idx_r) begin
                  rem_dirs_next[k] = rem_dirs[k+1];
                end
              end
              rem_count_next = rem_count - 3'd1;
            end else begin
              vis_we = 1'b1;
              vis_waddr = {nb_row, nb_col};
              vis_wdata = epoch;
              if (stack_count < CNT_W'(CELLS)) begin
                stk_we = 1'b1;
                stk_waddr = stack_count[STK_IDX_W-1:0];
                stk_wdata = {nb_row, nb_col};
                stack_count_next = stack_count + CNT_W'(1);
              end
              cur_row_next = nb_row;
              cur_col_next = nb_col;
              rem_dirs_next = DIRS_FULL;
              rem_count_next = 3'd4;
              res.carved = 1'b1;
              res.from_row = COORD_W'(cur_row);
              res.from_col = COORD_W'(cur_col);
              res.to_row = COORD_W'(nb_row);
              res.to_col = COORD_W'(nb_col);
            end
          end
          res.finished = (stack_count_next == '0);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      visited_mem[vis_waddr] <= vis_wdata;
    end
    if (in_fire) begin
      vis_rdata <= visited_mem[{nb_row_c, nb_col_c}];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (in_fire) begin
      stack_rdata <= stack_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_item.req_type;
      rem_idx_r <= pick.idx;
      nb_row <= nb_row_c;
      nb_col <= nb_col_c;
      off_r <= off_c;
      pop_r <= (rem_count == 3'd0);
      active_r <= (stack_count != '0);
    end
    if (commit) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_W'(16);
      col_count <= DIM_W'(16);
      start_row <= '0;
      start_col <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROW_COUNT: row_count <= cfg_data;
        CFG_COL_COUNT: col_count <= cfg_data;
        CFG_START_ROW: start_row <= cfg_data[COORD_W-1:0];
        CFG_START_COL: start_col <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clear_addr <= '0;
      clear_for_start <= 1'b0;
      epoch <= '0;
      cur_row <= '0;
      cur_col <= '0;
      stack_count <= '0;
      rem_dirs <= DIRS_FULL;
      rem_count <= 3'd4;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      epoch <= epoch_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      stack_count <= stack_count_next;
      rem_dirs <= rem_dirs_next;
      rem_count <= rem_count_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + CELL_W'(1);
        if (&clear_addr) begin
          clear_for_start <= 1'b0;
        end
      end else if (state_next == ST_CLEAR) begin
        clear_addr <= '0;
        clear_for_start <= 1'b1;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the grid maze carver, checked against a predictor.
module testbench;
  import gmdc_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int TARGET_ITEMS = 450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROW_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_maze_dfs_carver_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  in_item_t request_queue[$];
  out_item_t expected_reports[$];

  logic [4:0] grid_rows_reg = 5'd16;
  logic [4:0] grid_cols_reg = 5'd16;
  logic [3:0] origin_row_reg = 4'd0;
  logic [3:0] origin_col_reg = 4'd0;

  logic [3:0] here_row = 4'd0;
  logic [3:0] here_col = 4'd0;
  logic [3:0] trail_row [CELLS];
  logic [3:0] trail_col [CELLS];
  int trail_depth = 0;
  bit visited [CELLS];
  dir_e untried [4] = '{DIR_EAST, DIR_WEST, DIR_SOUTH, DIR_NORTH};
  int untried_count = 4;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int errors = 0;
  int requests_taken = 0;
  int starts_taken = 0;
  int links_seen = 0;
  int walks_done = 0;
  int reports_checked = 0;
  int settings_used = 0;

  out_item_t want;
  logic mismatch;

  function automatic int grid_extent(input int v, input int limit);
    return (v == 0) ? 1 : ((v > limit) ? limit : v);
  endfunction

  task automatic reload_dirs;
    untried = '{DIR_EAST, DIR_WEST, DIR_SOUTH, DIR_NORTH};
    untried_count = 4;
  endtask

  task automatic carve_predict(input in_item_t req);
    int rows;
    int cols;
    int pick;
    int nr;
    int nc;
    out_item_t rep;
    rows = grid_extent(grid_rows_reg, MAX_ROWS);
    cols = grid_extent(grid_cols_reg, MAX_COLS);
    rep = '0;
    requests_taken++;
    if (req.req_type == REQ_START) begin
      starts_taken++;
      here_row = (origin_row_reg < rows) ? origin_row_reg : 4'(rows - 1);
      here_col = (origin_col_reg < cols) ? origin_col_reg : 4'(cols - 1);
      for (int k = 0; k < CELLS; k++) visited[k] = 1'b0;
      visited[here_row * MAX_COLS + here_col] = 1'b1;
      trail_row[0] = here_row;
      trail_col[0] = here_col;
      trail_depth = 1;
      reload_dirs();
    end else if (trail_depth > 0) begin
      if (untried_count == 0) begin
        trail_depth--;
        here_row = trail_row[trail_depth];
        here_col = trail_col[trail_depth];
        reload_dirs();
        if (trail_depth == 0) walks_done++;
      end else begin
        pick = req.random_word % untried_count;
        nr = here_row;
        nc = here_col;
        case (untried[pick])
          DIR_EAST:  nc++;
          DIR_WEST:  nc--;
          DIR_SOUTH: nr++;
          DIR_NORTH: nr--;
        endcase
        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols || visited[nr * MAX_COLS + nc]) begin
          for (int k = pick; k < untried_count - 1; k++) untried[k] = untried[k + 1];
          untried_count--;
        end else begin
          rep.carved = 1'b1;
          rep.from_row = here_row;
          rep.from_col = here_col;
          rep.to_row = 4'(nr);
          rep.to_col = 4'(nc);
          visited[nr * MAX_COLS + nc] = 1'b1;
          here_row = 4'(nr);
          here_col = 4'(nc);
          if (trail_depth < CELLS) begin
            trail_row[trail_depth] = here_row;
            trail_col[trail_depth] = here_col;
            trail_depth++;
          end
          reload_dirs();
          links_seen++;
        end
      end
    end
    rep.finished = (trail_depth == 0);
    expected_reports = {expected_reports, rep};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) carve_predict(in_item);
      if (!in_valid || in_ready) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= request_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: result transaction with nothing expected: %h", $time, out_item);
        end else begin
          want = expected_reports.pop_front();
          reports_checked++;
          mismatch = (out_item.carved !== want.carved) || (out_item.from_row !== want.from_row) ||
                     (out_item.from_col !== want.from_col) || (out_item.to_row !== want.to_row) ||
                     (out_item.to_col !== want.to_col) || (out_item.finished !== want.finished);
          if (mismatch) begin
            errors++;
            $display("%0t: expected carved=%0d from=(%0d,%0d) to=(%0d,%0d) finished=%0d",
                     $time, want.carved, want.from_row, want.from_col, want.to_row,
                     want.to_col, want.finished);
            $display("%0t:   actual carved=%0d from=(%0d,%0d) to=(%0d,%0d) finished=%0d",
                     $time, out_item.carved, out_item.from_row, out_item.from_col,
                     out_item.to_row, out_item.to_col, out_item.finished);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_seen != hold_token) begin
        hold_seen <= hold_token;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic offer(input logic kind, input logic [RND_W-1:0] word);
    in_item_t it;
    it.req_type = kind;
    it.random_word = word;
    request_queue = {request_queue, it};
  endtask

  task automatic settle;
    while (request_queue.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_grid(input int rows, input int cols, input int sr, input int sc);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data <= 5'(rows);
    @(posedge clk);
    cfg_index <= CFG_COL_COUNT;
    cfg_data <= 5'(cols);
    @(posedge clk);
    cfg_index <= CFG_START_ROW;
    cfg_data <= 5'(sr);
    @(posedge clk);
    cfg_index <= CFG_START_COL;
    cfg_data <= 5'(sc);
    @(posedge clk);
    cfg_write <= 1'b0;
    grid_rows_reg = 5'(rows);
    grid_cols_reg = 5'(cols);
    origin_row_reg = 4'(sr);
    origin_col_reg = 4'(sc);
    settings_used++;
    @(negedge clk);
  endtask

  function automatic int odd_dim;
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1;
      2: return 16;
      3: return 17;
      default: return 31;
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    int rows_v;
    int cols_v;
    int sr_v;
    int sc_v;
    int cells;
    int walk_steps;
    int step_cap;
    int random_items;
    int mode;
    int sel;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset grid of 16 by 16: a step before any walk, then a short walk and a restart.
    offer(REQ_STEP, 16'h0000);
    offer(REQ_START, 16'hFFFF);
    offer(REQ_STEP, 16'h0000);
    offer(REQ_STEP, 16'hFFFF);
    offer(REQ_STEP, 16'h0001);
    offer(REQ_STEP, 16'h0001);
    offer(REQ_STEP, 16'h0002);
    offer(REQ_START, 16'h1234);
    offer(REQ_STEP, 16'h8000);
    settle();

    // A single cell: every direction is rejected, the walk ends, and a further step is idle.
    load_grid(1, 1, 0, 0);
    offer(REQ_START, 16'h0000);
    repeat (6) offer(REQ_STEP, 16'h5555);
    settle();

    // Zero rows, an oversized column count, and a start outside the grid.
    load_grid(0, 31, 15, 15);
    offer(REQ_START, 16'hAAAA);
    offer(REQ_STEP, 16'h0000);
    offer(REQ_STEP, 16'h0000);
    offer(REQ_STEP, 16'hFFFF);
    offer(REQ_STEP, 16'h7FFF);

    phase = 0;
    random_items = 0;
    while (random_items < TARGET_ITEMS) begin
      settle();
      case (phase)
        0: begin rows_v = 2; cols_v = 2; sr_v = 0; sc_v = 0; end
        1: begin rows_v = 16; cols_v = 16; sr_v = 15; sc_v = 15; end
        2: begin rows_v = 17; cols_v = 2; sr_v = 3; sc_v = 9; end
        default: begin
          sel = $urandom_range(0, 9);
          if (sel == 0) begin
            rows_v = odd_dim();
            cols_v = odd_dim();
            sr_v = $urandom_range(0, 15);
            sc_v = $urandom_range(0, 15);
          end else if (sel == 1) begin
            rows_v = 16;
            cols_v = 16;
            sr_v = $urandom_range(0, 15);
            sc_v = $urandom_range(0, 15);
          end else begin
            rows_v = $urandom_range(1, 4);
            cols_v = $urandom_range(1, 4);
            sr_v = $urandom_range(0, 5);
            sc_v = $urandom_range(0, 5);
          end
        end
      endcase
      load_grid(rows_v, cols_v, sr_v, sc_v);
      mode = phase % 4;
      send_idle_pct = (mode == 1) ? 54 : ((mode == 3) ? 23 : 0);
      stall_pct = (mode == 2) ? 54 : ((mode == 3) ? 23 : 0);
      if (phase % 5 == 1) hold_token++;
      cells = grid_extent(rows_v, MAX_ROWS) * grid_extent(cols_v, MAX_COLS);
      step_cap = (cells >= 64) ? 120 : 400;

      // Sometimes the previous walk goes on under the new grid size first.
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          offer(REQ_STEP, 16'($urandom));
          random_items++;
        end
      end
      offer(REQ_START, 16'($urandom));
      random_items++;
      walk_steps = (6 * cells + 4 < 100) ? 6 * cells + 4 : 100;
      repeat (walk_steps) offer(($urandom_range(0, 15) == 0) ? REQ_START : REQ_STEP, 16'($urandom));
      random_items += walk_steps;
      settle();
      while (trail_depth != 0 && walk_steps < step_cap) begin
        repeat (8) offer(REQ_STEP, 16'($urandom));
        walk_steps += 8;
        random_items += 8;
        settle();
      end
      phase++;
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Ran %0d requests (%0d starts) over %0d grid settings: %0d links, %0d walks done.",
             requests_taken, starts_taken, settings_used, links_seen, walks_done);
    $display("Checked %0d results, %0d mismatches.", reports_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out waiting for the block to finish.");
    $display("status: fail");
    $finish;
  end

endmodule
